// ===== rtl/fpsqrt_pkg.sv =====
// Package for the fixed-point square root block.
// Holds widths, register addresses and the pipeline stage record; no dependencies.

package fpsqrt_pkg;

    localparam int RADICAND_BITS   = 32;
    localparam int FRAC_FIELD_BITS = 5;
    localparam int ROOT_FIELD_BITS = 32;
    localparam int FRAC_BITS_MAX   = 16;

    // The scaled radicand is padded to an even width so that digit pairs stay aligned.
    localparam int SCALED_BITS = 2 * ((RADICAND_BITS + 1) / 2) + 2 * FRAC_BITS_MAX;
    localparam int ROOT_BITS   = SCALED_BITS / 2;
    localparam int REM_BITS    = ROOT_BITS + 2;
    localparam int LATENCY     = ROOT_BITS + 1;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    localparam logic [REG_IDX_BITS-1:0] REG_FRAC_BITS = '0;

    typedef struct packed {
        logic                   valid;
        logic [SCALED_BITS-1:0] scaled;
        logic [REM_BITS-1:0]    rem;
        logic [ROOT_BITS-1:0]   root;
    } t_stage;

endpackage

// ===== rtl/fpsqrt_cfg.sv =====
// Configuration register file holding the fractional-bit count.
// Depends on fpsqrt_pkg for address and data widths.

module fpsqrt_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fpsqrt_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [fpsqrt_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [fpsqrt_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                pready,
    output logic [fpsqrt_pkg::FRAC_FIELD_BITS-1:0] o_frac_bits
);
    import fpsqrt_pkg::*;

    logic [FRAC_FIELD_BITS-1:0] r_frac_bits;
    logic [FRAC_FIELD_BITS-1:0] n_frac_bits;
    logic [REG_IDX_BITS-1:0]    w_index;
    logic                       w_write;

    assign w_index = paddr[APB_ADDR_BITS-1:2];
    assign w_write = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        n_frac_bits = r_frac_bits;
        if (w_write && (w_index == REG_FRAC_BITS)) begin
            n_frac_bits = pwdata[FRAC_FIELD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_bits <= '0;
        end else begin
            r_frac_bits <= n_frac_bits;
        end
    end

    always_comb begin
        prdata = '0;
        if (w_index == REG_FRAC_BITS) begin
            prdata = APB_DATA_BITS'(r_frac_bits);
        end
    end

    assign o_frac_bits = r_frac_bits;

endmodule

// ===== rtl/fpsqrt_scale.sv =====
// Input stage: masks the radicand, saturates the fractional-bit count and scales by 4^F.
// Depends on fpsqrt_pkg for widths and the stage record.

module fpsqrt_scale (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [fpsqrt_pkg::ROOT_FIELD_BITS-1:0] i_radicand,
    input  logic [fpsqrt_pkg::FRAC_FIELD_BITS-1:0] i_frac_bits,
    output fpsqrt_pkg::t_stage                     o_stage
);
    import fpsqrt_pkg::*;

    logic                       r_valid;
    logic [SCALED_BITS-1:0]     r_scaled;
    logic [SCALED_BITS-1:0]     n_scaled;
    logic [FRAC_FIELD_BITS-1:0] w_frac_sat;

    always_comb begin
        if (i_frac_bits > FRAC_FIELD_BITS'(FRAC_BITS_MAX)) begin
            w_frac_sat = FRAC_FIELD_BITS'(FRAC_BITS_MAX);
        end else begin
            w_frac_sat = i_frac_bits;
        end
        n_scaled = SCALED_BITS'(i_radicand[RADICAND_BITS-1:0]) << {w_frac_sat, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scaled <= n_scaled;
    end

    assign o_stage.valid  = r_valid;
    assign o_stage.scaled = r_scaled;
    assign o_stage.rem    = '0;
    assign o_stage.root   = '0;

endmodule

// ===== rtl/fpsqrt_stage.sv =====
// One digit stage of the square root pipeline: yields one root bit per item.
// Depends on fpsqrt_pkg for widths and the stage record.

module fpsqrt_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fpsqrt_pkg::t_stage i_stage,
    output fpsqrt_pkg::t_stage o_stage
);
    import fpsqrt_pkg::*;

    logic                   r_valid;
    logic [SCALED_BITS-1:0] r_scaled;
    logic [REM_BITS-1:0]    r_rem;
    logic [ROOT_BITS-1:0]   r_root;
    logic [SCALED_BITS-1:0] n_scaled;
    logic [REM_BITS-1:0]    n_rem;
    logic [ROOT_BITS-1:0]   n_root;
    logic [REM_BITS-1:0]    w_rem_shift;
    logic [REM_BITS-1:0]    w_trial;

    always_comb begin
        w_rem_shift = {i_stage.rem[REM_BITS-3:0], i_stage.scaled[SCALED_BITS-1 -: 2]};
        w_trial     = {i_stage.root, 2'b01};
        n_scaled    = {i_stage.scaled[SCALED_BITS-3:0], 2'b00};
        if (w_rem_shift >= w_trial) begin
            n_rem  = w_rem_shift - w_trial;
            n_root = {i_stage.root[ROOT_BITS-2:0], 1'b1};
        end else begin
            n_rem  = w_rem_shift;
            n_root = {i_stage.root[ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scaled <= n_scaled;
        r_rem    <= n_rem;
        r_root   <= n_root;
    end

    assign o_stage.valid  = r_valid;
    assign o_stage.scaled = r_scaled;
    assign o_stage.rem    = r_rem;
    assign o_stage.root   = r_root;

endmodule

// ===== rtl/fixed_point_square_root.sv =====
// Fixed-point square root: root = floor(sqrt(radicand * 4^F)), F = min(frac_bits, 16).
// An accepted transfer has its result on the ports once it has left the last digit stage.
// Throughput: one transfer per cycle; busy stays low because every stage advances each cycle.
// The latency is set by one scaling stage plus 32 digit stages, one root bit each.
// Synchronous active-low reset clears all valid bits and sets frac_bits to 0.
// Depends on fpsqrt_pkg, fpsqrt_cfg, fpsqrt_scale and fpsqrt_stage.

module fixed_point_square_root (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [fpsqrt_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [fpsqrt_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [fpsqrt_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                   pready,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [fpsqrt_pkg::ROOT_FIELD_BITS-1:0] i_radicand,
    output logic                                   o_valid,
    output logic [fpsqrt_pkg::ROOT_FIELD_BITS-1:0] o_root
);
    import fpsqrt_pkg::*;

    logic [FRAC_FIELD_BITS-1:0] w_frac_bits;
    logic                       w_accept;
    t_stage                     w_stage [0:ROOT_BITS];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    fpsqrt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_frac_bits (w_frac_bits)
    );

    fpsqrt_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_radicand  (i_radicand),
        .i_frac_bits (w_frac_bits),
        .o_stage     (w_stage[0])
    );

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_digit
        fpsqrt_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    assign o_valid = w_stage[ROOT_BITS].valid;
    assign o_root  = ROOT_FIELD_BITS'(w_stage[ROOT_BITS].root);

endmodule

// ===== rtl/fpsqrt_checker.sv =====
// Port-level checker for the fixed-point square root block, bound to the top level.
// Depends on fpsqrt_pkg for the pipeline latency and port widths.

module fpsqrt_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic [fpsqrt_pkg::ROOT_FIELD_BITS-1:0] i_radicand,
    input logic                                   o_valid,
    input logic [fpsqrt_pkg::ROOT_FIELD_BITS-1:0] o_root
);
    import fpsqrt_pkg::*;

    // Every accepted transfer yields exactly one result after the fixed latency.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted transfer produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching accepted transfer");

    // The root of zero is zero for any fractional-bit count.
    a_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_radicand == '0)) |-> ##LATENCY (o_root == '0))
        else $error("root of zero is not zero");

    // The root of one is 2^F, a single set bit.
    a_unit_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_radicand == ROOT_FIELD_BITS'(1))) |-> ##LATENCY $onehot(o_root))
        else $error("root of one is not a power of two");

endmodule

bind fixed_point_square_root fpsqrt_checker u_checker (.*);
